>>> sv/b64d_pkg.sv
// Shared types, codes and the character classifier for the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int unsigned FifoDepthDefault = 4;
  localparam logic [15:0] CapacityReset    = 16'hFFFF;

  // Classifier codes beyond the 64 alphabet values
  localparam logic [6:0] SymSkip = 7'd64;
  localparam logic [6:0] SymPad  = 7'd65;
  localparam logic [6:0] SymBad  = 7'd66;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadChar  = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Work handed from the classifier front to the output back end
  typedef struct packed {
    logic [2:0][7:0] data;       // data[0] goes out first
    logic [1:0]      nbytes;
    logic            has_status;
    logic [1:0]      status;
    logic [15:0]     count;
  } job_t;

  function automatic logic [6:0] classify(input logic [7:0] ch);
    logic [6:0] sym;
    sym = SymBad;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      sym = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      sym = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      sym = 7'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      sym = 7'd62;
    end else if (ch == 8'h2F) begin
      sym = 7'd63;
    end else if (ch == 8'h0A) begin
      sym = SymSkip;
    end else if (ch == 8'h3D) begin
      sym = SymPad;
    end
    return sym;
  endfunction

endpackage

>>> sv/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, job queue and back end.
//
//   port group     | direction | handshake             | payload
//   ---------------+-----------+-----------------------+-----------------------------------
//   input chars    | in        | in_valid_i/in_stall_o | char_present_i, in_char_i, msg_end_i
//   decoded output | out       | out_valid_o/out_stall_i| kind_o, out_byte_o, status_o,
//                  |           |                       | out_count_o, run_last_o
//   capacity reg   | in        | cfg_we_i              | cfg_wdata_i
//
// One character is accepted per cycle while the job queue has room.
// Each character yields a job of zero to four results; the back end emits one result
// per cycle from its output register while the output is not stalled.
// The queue of FifoDepth jobs absorbs bursts; the front stalls only when it is full.
// Reset clears all decode state and sets the capacity to 65535.
`timescale 1ns / 1ps
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        char_present_i,
  input  logic [7:0]  in_char_i,
  input  logic        msg_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_count_o,
  output logic        run_last_o
);

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, head_job;

  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_present_i (char_present_i),
    .in_char_i      (in_char_i),
    .msg_end_i      (msg_end_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (push_job)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .empty_o    (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .out_count_o (out_count_o),
    .run_last_o  (run_last_o)
  );

endmodule

>>> sv/b64d_front.sv
// Front end: accepts characters, tracks the decode state and builds output jobs.
`timescale 1ns / 1ps
module b64d_front import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        char_present_i,
  input  logic [7:0]  in_char_i,
  input  logic        msg_end_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output job_t        q_job_o
);

  logic [15:0] cap_q;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] bc_q, bc_d;
  logic        pad_q, pad_d;
  logic [1:0]  err_q, err_d;
  logic        accept;
  logic [6:0]  sym;
  job_t        job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sym        = classify(in_char_i);

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    bc_d  = bc_q;
    pad_d = pad_q;
    err_d = err_q;
    job   = '0;

    if (char_present_i && err_q == StOk && !pad_q) begin
      if (sym == SymSkip) begin
        // line feed: nothing to do
      end else if (sym == SymBad) begin
        err_d = StBadChar;
      end else if (sym == SymPad) begin
        pad_d = 1'b1;
      end else if (cnt_q == 2'd3) begin
        if ({1'b0, bc_q} + 17'd3 > {1'b0, cap_q}) begin
          err_d = StOverflow;
        end else begin
          job.data[0] = acc_q[17:10];
          job.data[1] = acc_q[9:2];
          job.data[2] = {acc_q[1:0], sym[5:0]};
          job.nbytes  = 2'd3;
          bc_d        = bc_q + 16'd3;
        end
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = {acc_q[11:0], sym[5:0]};
        cnt_d = cnt_q + 2'd1;
      end
    end

    if (msg_end_i) begin
      // flush the leftover sextets; a group above never leaves a leftover
      if (err_d == StOk) begin
        if (cnt_d == 2'd3) begin
          if ({1'b0, bc_d} + 17'd2 > {1'b0, cap_q}) begin
            err_d = StOverflow;
          end else begin
            job.data[0] = acc_d[17:10];
            job.data[1] = acc_d[9:2];
            job.nbytes  = 2'd2;
            bc_d        = bc_d + 16'd2;
          end
        end else if (cnt_d == 2'd2) begin
          if ({1'b0, bc_d} + 17'd1 > {1'b0, cap_q}) begin
            err_d = StOverflow;
          end else begin
            job.data[0] = acc_d[11:4];
            job.nbytes  = 2'd1;
            bc_d        = bc_d + 16'd1;
          end
        end
      end
      job.has_status = 1'b1;
      job.status     = err_d;
      job.count      = bc_d;
      acc_d = '0;
      cnt_d = '0;
      bc_d  = '0;
      pad_d = 1'b0;
      err_d = StOk;
    end
  end

  assign q_job_o  = job;
  assign q_push_o = accept && (job.has_status || job.nbytes != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
      acc_q <= '0;
      cnt_q <= '0;
      bc_q  <= '0;
      pad_q <= 1'b0;
      err_q <= StOk;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        bc_q  <= bc_d;
        pad_q <= pad_d;
        err_q <= err_d;
      end
    end
  end

endmodule

>>> sv/b64d_fifo.sv
// Small job queue between the front and back ends.
`timescale 1ns / 1ps
module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t head_job_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/b64d_back.sv
// Back end: expands each job into data bytes and, if present, a status record, one per cycle unless stalled.
`timescale 1ns / 1ps
module b64d_back import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_job_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_count_o,
  output logic        run_last_o
);

  logic [1:0]  idx_q;
  logic        valid_q;
  logic        kind_q, last_q;
  logic [7:0]  byte_q;
  logic [1:0]  status_q;
  logic [15:0] count_q;
  logic        load;
  logic [2:0]  total;
  logic        is_last, is_data;

  assign load    = (!valid_q || !out_stall_i) && !q_empty_i;
  assign total   = {1'b0, head_job_i.nbytes} + {2'b00, head_job_i.has_status};
  assign is_last = ({1'b0, idx_q} + 3'd1 == total);
  assign is_data = (idx_q < head_job_i.nbytes);
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      valid_q  <= 1'b0;
      kind_q   <= KindData;
      last_q   <= 1'b0;
      byte_q   <= '0;
      status_q <= StOk;
      count_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        last_q  <= is_last;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
        if (is_data) begin
          kind_q   <= KindData;
          byte_q   <= head_job_i.data[idx_q];
          status_q <= StOk;
          count_q  <= '0;
        end else begin
          kind_q   <= KindStatus;
          byte_q   <= '0;
          status_q <= head_job_i.status;
          count_q  <= head_job_i.count;
        end
      end else if (!out_stall_i) begin
        // transaction taken, nothing new to show
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign out_count_o = count_q;
  assign run_last_o  = last_q;

endmodule

>>> bench/base64_stream_decoder_tb.sv
// Self-checking testbench for the base64 stream decoder: random and directed messages.
`timescale 1ns / 1ps
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int IdlePct      = 18;
  localparam int SettleCycles = 16;
  localparam int EndCycles    = 24;
  localparam int CycleLimit   = 200000;
  localparam int RandomItems  = 460;
  localparam int NumPhases    = 10;

  typedef enum logic [1:0] {OpChar, OpCapacity, OpDrain} stim_op_e;

  typedef struct {
    stim_op_e    op;
    logic        present;
    logic [7:0]  ch;
    logic        last;
    logic [15:0] cap;
  } stim_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] count;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we_q = 1'b0;
  logic [15:0] cfg_wdata_q = 16'd0;
  logic        in_valid_q = 1'b0;
  logic        char_present_q = 1'b0;
  logic [7:0]  in_char_q = 8'd0;
  logic        msg_end_q = 1'b0;
  logic        out_stall_q = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic [15:0] out_count_o;
  logic        run_last_o;

  stim_t   stim_q[$];
  result_t decoded_q[$];

  // decoder shadow state
  logic [15:0] capacity = CapacityReset;
  logic [17:0] acc = '0;
  logic [1:0]  nsext = '0;
  logic [15:0] nbytes = '0;
  logic        pad_hit = 1'b0;
  logic [1:0]  err = StOk;

  int stim_items = 0;
  int chars_taken = 0;
  int results_seen = 0;
  int msgs_seen = 0;
  int bad_seen = 0;
  int ovf_seen = 0;
  int cap_writes = 0;
  int mismatches = 0;
  int quiet_cnt = 0;
  int cycle_cnt = 0;
  logic calm;

  // one stretch of the run with no idling on either side
  assign calm = (chars_taken >= 200) && (chars_taken < 320);

  base64_stream_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we_q),
    .cfg_wdata_i    (cfg_wdata_q),
    .in_valid_i     (in_valid_q),
    .in_stall_o     (in_stall_o),
    .char_present_i (char_present_q),
    .in_char_i      (in_char_q),
    .msg_end_i      (msg_end_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_q),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .out_count_o    (out_count_o),
    .run_last_o     (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  function automatic logic [6:0] char_sextet(logic [7:0] ch);
    logic [6:0] code;
    code = SymBad;
    case (ch)
      8'h2B: code = 7'd62;
      8'h2F: code = 7'd63;
      8'h0A: code = SymSkip;
      8'h3D: code = SymPad;
      default: begin
        if (ch >= "A" && ch <= "Z") code = 7'(ch - "A");
        else if (ch >= "a" && ch <= "z") code = 7'(ch - "a" + 8'd26);
        else if (ch >= "0" && ch <= "9") code = 7'(ch - "0" + 8'd52);
      end
    endcase
    return code;
  endfunction

  function automatic logic [7:0] sextet_char(int s);
    if (s < 26) return 8'(65 + s);
    if (s < 52) return 8'(97 + s - 26);
    if (s < 62) return 8'(48 + s - 52);
    return (s == 62) ? 8'h2B : 8'h2F;
  endfunction

  // Queue the first n bytes of grp, or flag overflow if they do not fit.
  function automatic void push_bytes(logic [23:0] grp, int n);
    result_t r;
    if (int'(nbytes) + n > int'(capacity)) begin
      err = StOverflow;
    end else begin
      for (int i = 0; i < n; i++) begin
        r = '{KindData, grp[23 - 8 * i -: 8], StOk, 16'd0, 1'b0};
        decoded_q.push_back(r);
      end
      nbytes = nbytes + 16'(n);
    end
  endfunction

  function automatic void decode_char(logic present, logic [7:0] ch, logic last);
    logic [6:0] sym;
    result_t r;
    int first;
    first = decoded_q.size();
    if (present && err == StOk && !pad_hit) begin
      sym = char_sextet(ch);
      if (sym == SymSkip) begin
        // line feed: nothing to do
      end else if (sym == SymBad) begin
        err = StBadChar;
      end else if (sym == SymPad) begin
        pad_hit = 1'b1;
      end else if (nsext == 2'd3) begin
        push_bytes({acc, sym[5:0]}, 3);
        acc = '0;
        nsext = '0;
      end else begin
        acc = {acc[11:0], sym[5:0]};
        nsext = nsext + 2'd1;
      end
    end
    if (last) begin
      if (err == StOk) begin
        if (nsext == 2'd3) push_bytes({acc[17:2], 8'h00}, 2);
        else if (nsext == 2'd2) push_bytes({acc[11:4], 16'h0000}, 1);
      end
      r = '{KindStatus, 8'd0, err, nbytes, 1'b0};
      decoded_q.push_back(r);
      acc = '0;
      nsext = '0;
      nbytes = '0;
      pad_hit = 1'b0;
      err = StOk;
    end
    if (decoded_q.size() > first) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // driver: present queued transactions, write the capacity only when idle
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid_q <= 1'b0;
      cfg_we_q <= 1'b0;
      quiet_cnt = 0;
    end else begin : drive
      stim_t head;
      logic  nxt_valid;
      logic  nxt_we;
      logic  load;
      nxt_valid = in_valid_q;
      nxt_we = 1'b0;
      load = 1'b0;
      if (in_valid_q && !in_stall_o) begin
        decode_char(char_present_q, in_char_q, msg_end_q);
        chars_taken++;
        nxt_valid = 1'b0;
      end
      if (!in_valid_q && decoded_q.size() == 0) quiet_cnt++;
      else quiet_cnt = 0;
      if (!nxt_valid && stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.op)
          OpChar: begin
            if (calm || $urandom_range(99) >= IdlePct) begin
              load = 1'b1;
              nxt_valid = 1'b1;
              stim_q.delete(0);
            end
          end
          OpCapacity: begin
            if (quiet_cnt >= SettleCycles) begin
              nxt_we = 1'b1;
              capacity = head.cap;
              cap_writes++;
              quiet_cnt = 0;
              stim_q.delete(0);
            end
          end
          default: begin
            // hold off until the block has drained
            if (quiet_cnt >= SettleCycles) stim_q.delete(0);
          end
        endcase
      end
      in_valid_q <= nxt_valid;
      cfg_we_q <= nxt_we;
      if (load) begin
        char_present_q <= head.present;
        in_char_q <= head.ch;
        msg_end_q <= head.last;
      end
      if (nxt_we) cfg_wdata_q <= head.cap;
    end
  end

  // monitor: compare each accepted transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall_q <= 1'b0;
    end else begin : watch
      result_t want;
      if (out_valid_o && !out_stall_q) begin
        results_seen++;
        if (kind_o === KindStatus) begin
          msgs_seen++;
          if (status_o === StBadChar) bad_seen++;
          if (status_o === StOverflow) ovf_seen++;
        end
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual kind %0h byte %0h",
                   $time, kind_o, out_byte_o);
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind_o));
          check_field("out_byte", 16'(want.data), 16'(out_byte_o));
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("out_count", want.count, out_count_o);
          check_field("run_last", 16'(want.last), 16'(run_last_o));
        end
      end
      out_stall_q <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               decoded_q.size());
      $display("base64_stream_decoder verification failed");
      $finish;
    end
  end

  task automatic put_char(logic present, logic [7:0] ch, logic last);
    stim_t s;
    s = '{OpChar, present, ch, last, 16'd0};
    stim_q.push_back(s);
    if (present || last) stim_items++;
  endtask

  task automatic put_text(string txt, logic end_on_last);
    for (int i = 0; i < txt.len(); i++) begin
      put_char(1'b1, txt[i], end_on_last && (i == txt.len() - 1));
    end
  endtask

  task automatic put_capacity(logic [15:0] cap);
    stim_t s;
    s = '{OpCapacity, 1'b0, 8'd0, 1'b0, cap};
    stim_q.push_back(s);
  endtask

  task automatic put_drain();
    stim_t s;
    s = '{OpDrain, 1'b0, 8'd0, 1'b0, 16'd0};
    stim_q.push_back(s);
  endtask

  // Mostly well-formed messages with random content; a few carry stray bytes.
  task automatic put_message();
    int nsym;
    int broken;
    int ending;
    nsym = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 9);
    broken = ($urandom_range(99) < 12);
    ending = $urandom_range(3);
    for (int i = 0; i < nsym; i++) begin
      if ($urandom_range(99) < 6) put_char(1'b1, 8'h0A, 1'b0);
      if ($urandom_range(99) < 4) put_char(1'b0, 8'($urandom), 1'b0);
      if (broken && $urandom_range(99) < 15) put_char(1'b1, 8'($urandom), 1'b0);
      put_char(1'b1, sextet_char($urandom_range(63)), 1'b0);
    end
    case (ending)
      0: begin
        if (nsym % 4 >= 2) put_char(1'b1, 8'h3D, 1'b0);
        if (nsym % 4 == 2) put_char(1'b1, 8'h3D, 1'b0);
        // anything after the pad is ignored, even garbage
        if ($urandom_range(1)) put_char(1'b1, 8'($urandom), 1'b0);
        put_char(1'b0, 8'($urandom), 1'b1);
      end
      1: begin
        if (nsym > 0 && stim_q[stim_q.size() - 1].present) begin
          stim_q[stim_q.size() - 1].last = 1'b1;
        end else begin
          put_char(1'b0, 8'($urandom), 1'b1);
        end
      end
      2: put_char(1'b0, 8'($urandom), 1'b1);
      default: put_char(1'b1, 8'($urandom), 1'b1);
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] caps [NumPhases];
    int directed;
    caps = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd5, 16'($urandom_range(12)),
             16'd8, 16'hFFFE, 16'($urandom_range(30)), 16'hFFFF};

    // alphabet extremes, line feed, group plus status on one item
    put_text("AZaz", 1'b0);
    put_char(1'b1, 8'h0A, 1'b0);
    put_text("09+/", 1'b1);
    put_char(1'b0, 8'hFF, 1'b0);
    // lone sextet dropped, byte after the pad ignored
    put_text("Q=", 1'b0);
    put_char(1'b1, 8'h00, 1'b1);
    // bad character, rest of message ignored
    put_char(1'b1, 8'hFF, 1'b0);
    put_text("AB", 1'b1);
    put_text("TWE", 1'b1);
    put_text("TQ", 1'b0);
    put_char(1'b0, 8'h5A, 1'b1);
    // overflowing group at a tight capacity
    put_capacity(16'd2);
    put_text("TWFu", 1'b1);
    put_text("TQ", 1'b1);
    directed = stim_items;

    for (int p = 0; p < NumPhases; p++) begin
      put_capacity(caps[p]);
      while (stim_items < directed + (p + 1) * RandomItems / NumPhases) begin
        put_message();
        if (p == 4 && stim_items >= directed + (p * 2 + 1) * RandomItems / (2 * NumPhases)
            && stim_q[stim_q.size() - 1].op == OpChar && stim_q[stim_q.size() - 1].last) begin
          put_drain();
        end
      end
    end

    while (!rst_n || stim_q.size() != 0 || in_valid_q || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (EndCycles) @(posedge clk_i);

    $display("Fed %0d items into %0d results across %0d messages, %0d capacity writes",
             chars_taken, results_seen, msgs_seen, cap_writes);
    $display("Messages closed with bad character: %0d, with overflow: %0d",
             bad_seen, ovf_seen);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("base64_stream_decoder verification clean");
    end else begin
      $display("base64_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
